// ----- rtl/core/ordered_ring_task_queue_core_defines.svh -----
// Assertion macros for the ordered ring task queue core.
// Included by the files that assert; depends on nothing else.
`ifndef ORDERED_RING_TASK_QUEUE_CORE_DEFINES_SVH
`define ORDERED_RING_TASK_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ORTQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ORTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ortq_pkg.sv -----
// Shared constants, types and index helpers for the ordered ring task queue.
// Used by the store, the sequencer and the top level; depends on nothing.
package ortq_pkg;

   // Queue geometry.
   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int POS_W = 4;
   localparam int COUNT_OUT_W = 4;
   localparam int CMP_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

   typedef logic [IDX_W-1:0] idx_type;

   // Command codes.
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_POP    = 2'd2;
   localparam logic [1:0] MODE_REMOVE = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_BADPOS = 2'd3;

   typedef struct packed {
      logic [1:0]       mode;
      logic [31:0]      key;
      logic [31:0]      payload;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [31:0]            out_key;
      logic [31:0]            out_payload;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] payload;
   } entry_type;

   // Store port commands from the sequencer.
   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } mem_cmd_type;

   // Sequencer status towards the top level.
   typedef struct packed {
      logic       idle;
      logic       done;
      logic [1:0] status;
      entry_type  taken;
      idx_type    count;
   } seq_out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_FINAL,
      ST_RM_TAKE,
      ST_RM_SHIFT,
      ST_DONE
   } state_type;

   // Circular index stepping.
   function automatic idx_type wrap_next(input idx_type i);
      wrap_next = (i == idx_type'(SLOTS - 1)) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type wrap_prev(input idx_type i);
      wrap_prev = (i == '0) ? idx_type'(SLOTS - 1) : idx_type'(i - 1'b1);
   endfunction

endpackage

// ----- rtl/core/ortq_store.sv -----
// Slot store of the ordered ring task queue with its key comparator.
// One write port, one registered read port; depends on ortq_pkg.
module ortq_store (
   input  logic                 clock,
   input  ortq_pkg::mem_cmd_type mem_cmd,
   input  logic [31:0]          cmp_key,
   output ortq_pkg::entry_type  rd_data,
   output logic                 key_gt
);

   ortq_pkg::entry_type slot_store_ff [ortq_pkg::SLOTS];
   ortq_pkg::entry_type rd_ff;

   // Write and registered read of the slot memory.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         slot_store_ff[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_ff <= slot_store_ff[mem_cmd.rd_addr];
      end
   end

   // The shared compare: is the entry just read later than the new key?
   assign rd_data = rd_ff;
   assign key_gt  = (rd_ff.key > cmp_key);

endmodule

// ----- rtl/core/ortq_seq.sv -----
// Command sequencer of the ordered ring task queue: ring pointers, counts and
// the shift loops that walk the store one slot per cycle. Depends on ortq_pkg.
module ortq_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  ortq_pkg::req_type     req,
   input  logic                  out_free,
   input  ortq_pkg::entry_type   rd_data,
   input  logic                  key_gt,
   output ortq_pkg::mem_cmd_type mem_cmd,
   output logic [31:0]           cmp_key,
   output ortq_pkg::seq_out_type seq_out
);

   ortq_pkg::state_type state_ff, state_in;
   ortq_pkg::idx_type   head_ff, head_in;
   ortq_pkg::idx_type   tail_ff, tail_in;
   ortq_pkg::idx_type   count_ff, count_in;
   ortq_pkg::idx_type   ptr_ff, ptr_in;
   ortq_pkg::idx_type   left_ff, left_in;
   ortq_pkg::entry_type entry_ff, entry_in;
   ortq_pkg::entry_type taken_ff, taken_in;
   logic [1:0]          status_ff, status_in;

   logic                         is_insert;
   logic                         full;
   logic                         empty;
   logic [ortq_pkg::CMP_W-1:0]   pos_c;
   logic                         pos_oob;
   ortq_pkg::idx_type            pos_idx;
   logic [ortq_pkg::CMP_W-1:0]   pos_off;
   logic                         bad_pos;
   ortq_pkg::idx_type            rm_start;
   ortq_pkg::idx_type            ptr_prev;
   logic                         commit_ins;
   logic                         commit_rm;

   // Command decode and the occupancy check for remove-at-slot.
   always_comb begin
      is_insert = (req.mode == ortq_pkg::MODE_APPEND) || (req.mode == ortq_pkg::MODE_INSERT);
      full      = (count_ff == ortq_pkg::idx_type'(ortq_pkg::SLOTS - 1));
      empty     = (count_ff == '0);
      pos_c     = ortq_pkg::CMP_W'(req.position);
      pos_oob   = (pos_c >= ortq_pkg::CMP_W'(ortq_pkg::SLOTS));
      pos_idx   = ortq_pkg::idx_type'(req.position);
      pos_off   = ortq_pkg::CMP_W'(pos_idx)
                + ((pos_idx < head_ff) ? ortq_pkg::CMP_W'(ortq_pkg::SLOTS) : '0)
                - ortq_pkg::CMP_W'(head_ff);
      bad_pos   = pos_oob || (pos_off >= ortq_pkg::CMP_W'(count_ff));
      rm_start  = (req.mode == ortq_pkg::MODE_POP) ? head_ff : pos_idx;
      ptr_prev  = ortq_pkg::wrap_prev(ptr_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ortq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (is_insert) begin
                  if (full || (req.mode == ortq_pkg::MODE_APPEND) || empty) begin
                     state_in = ortq_pkg::ST_DONE;
                  end else begin
                     state_in = ortq_pkg::ST_INS_CMP;
                  end
               end else if (empty || ((req.mode == ortq_pkg::MODE_REMOVE) && bad_pos)) begin
                  state_in = ortq_pkg::ST_DONE;
               end else begin
                  state_in = ortq_pkg::ST_RM_TAKE;
               end
            end
         end
         ortq_pkg::ST_INS_CMP: begin
            if (!key_gt) begin
               state_in = ortq_pkg::ST_DONE;
            end else if (left_ff == ortq_pkg::idx_type'(1)) begin
               state_in = ortq_pkg::ST_INS_FINAL;
            end
         end
         ortq_pkg::ST_INS_FINAL: begin
            state_in = ortq_pkg::ST_DONE;
         end
         ortq_pkg::ST_RM_TAKE: begin
            state_in = (ptr_ff == head_ff) ? ortq_pkg::ST_DONE : ortq_pkg::ST_RM_SHIFT;
         end
         ortq_pkg::ST_RM_SHIFT: begin
            if (ptr_prev == head_ff) begin
               state_in = ortq_pkg::ST_DONE;
            end
         end
         ortq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ortq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ortq_pkg::ST_IDLE;
         end
      endcase
   end

   // Store commands and datapath updates for each step.
   always_comb begin
      mem_cmd    = '0;
      ptr_in     = ptr_ff;
      left_in    = left_ff;
      entry_in   = entry_ff;
      taken_in   = taken_ff;
      status_in  = status_ff;
      commit_ins = 1'b0;
      commit_rm  = 1'b0;
      case (state_ff)
         ortq_pkg::ST_IDLE: begin
            if (req_valid) begin
               entry_in  = '{key: req.key, payload: req.payload};
               taken_in  = '0;
               status_in = ortq_pkg::STATUS_OK;
               if (is_insert) begin
                  if (full) begin
                     status_in = ortq_pkg::STATUS_FULL;
                  end else if ((req.mode == ortq_pkg::MODE_APPEND) || empty) begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_addr = tail_ff;
                     mem_cmd.wr_data = '{key: req.key, payload: req.payload};
                     commit_ins      = 1'b1;
                  end else begin
                     mem_cmd.rd_en   = 1'b1;
                     mem_cmd.rd_addr = ortq_pkg::wrap_prev(tail_ff);
                     ptr_in          = tail_ff;
                     left_in         = count_ff;
                  end
               end else if (empty) begin
                  status_in = ortq_pkg::STATUS_EMPTY;
               end else if ((req.mode == ortq_pkg::MODE_REMOVE) && bad_pos) begin
                  status_in = ortq_pkg::STATUS_BADPOS;
               end else begin
                  mem_cmd.rd_en   = 1'b1;
                  mem_cmd.rd_addr = rm_start;
                  ptr_in          = rm_start;
               end
            end
         end
         ortq_pkg::ST_INS_CMP: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = ptr_ff;
            if (key_gt) begin
               // Move the later entry back one slot and fetch the next one.
               mem_cmd.wr_data = rd_data;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = ortq_pkg::wrap_prev(ptr_prev);
               ptr_in          = ptr_prev;
               left_in         = ortq_pkg::idx_type'(left_ff - 1'b1);
            end else begin
               mem_cmd.wr_data = entry_ff;
               commit_ins      = 1'b1;
            end
         end
         ortq_pkg::ST_INS_FINAL: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = ptr_ff;
            mem_cmd.wr_data = entry_ff;
            commit_ins      = 1'b1;
         end
         ortq_pkg::ST_RM_TAKE: begin
            taken_in = rd_data;
            if (ptr_ff == head_ff) begin
               commit_rm = 1'b1;
            end else begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = ptr_prev;
            end
         end
         ortq_pkg::ST_RM_SHIFT: begin
            // Move the earlier entry forward one slot towards the removed one.
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = ptr_ff;
            mem_cmd.wr_data = rd_data;
            ptr_in          = ptr_prev;
            if (ptr_prev == head_ff) begin
               commit_rm = 1'b1;
            end else begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = ortq_pkg::wrap_prev(ptr_prev);
            end
         end
         default: begin
         end
      endcase
   end

   // Ring pointer and count updates when a command completes.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (commit_ins) begin
         tail_in  = ortq_pkg::wrap_next(tail_ff);
         count_in = ortq_pkg::idx_type'(count_ff + 1'b1);
      end else if (commit_rm) begin
         head_in  = ortq_pkg::wrap_next(head_ff);
         count_in = ortq_pkg::idx_type'(count_ff - 1'b1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ortq_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current command.
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      left_ff   <= left_in;
      entry_ff  <= entry_in;
      taken_ff  <= taken_in;
      status_ff <= status_in;
   end

   assign cmp_key        = entry_ff.key;
   assign seq_out.idle   = (state_ff == ortq_pkg::ST_IDLE);
   assign seq_out.done   = (state_ff == ortq_pkg::ST_DONE);
   assign seq_out.status = status_ff;
   assign seq_out.taken  = taken_ff;
   assign seq_out.count  = count_ff;

endmodule

// ----- rtl/core/ordered_ring_task_queue_core.sv -----
// Ordered ring task queue: a result register over the sequencer and slot store.
// Ordered insert into a non-empty queue moves the later entries back one slot each, and
// remove-at-slot moves the earlier entries forward; the shift loop walks one slot per cycle.
// A new command is stalled until the sequencer is idle again; a held result does not block
// the next command's work.
// Reset is synchronous: head, tail and count clear, the slot store keeps its contents.
`include "ordered_ring_task_queue_core_defines.svh"

module ordered_ring_task_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ortq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ortq_pkg::rsp_type rsp_data
);

   ortq_pkg::mem_cmd_type mem_cmd;
   ortq_pkg::entry_type   rd_data;
   ortq_pkg::seq_out_type seq_out;
   ortq_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic                  key_gt;
   logic [31:0]           cmp_key;
   logic                  out_free;
   logic                  rsp_load;

   ortq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req_data),
      .out_free  (out_free),
      .rd_data   (rd_data),
      .key_gt    (key_gt),
      .mem_cmd   (mem_cmd),
      .cmp_key   (cmp_key),
      .seq_out   (seq_out)
   );

   ortq_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .cmp_key (cmp_key),
      .rd_data (rd_data),
      .key_gt  (key_gt)
   );

   // The result register is free when empty or when its transfer completes now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = seq_out.done && out_free;
   assign req_stall = !seq_out.idle;

   always_comb begin
      rsp_in.status      = seq_out.status;
      rsp_in.out_key     = seq_out.taken.key;
      rsp_in.out_payload = seq_out.taken.payload;
      rsp_in.entry_count = ortq_pkg::COUNT_OUT_W'(seq_out.count);
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= seq_out.done;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the sequencer and result register.
   `ORTQ_ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall,
                     "accepted command did not hold off the next one")
   `ORTQ_ASSERT_NOW(a_count_bound, seq_out.idle,
                    seq_out.count <= ortq_pkg::idx_type'(ortq_pkg::SLOTS - 1),
                    "entry count beyond capacity")
   `ORTQ_ASSERT_NEXT(a_done_waits, seq_out.done && rsp_valid && rsp_stall, seq_out.done,
                     "finished result lost while output stalled")

endmodule
